### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### rtl/qapp_pkg.sv
// Shared types and constants of the quarter arc point projector.
`default_nettype none
package qapp_pkg;
    localparam int WIDE_BITS = 64;
    localparam int ZB = 32;
    localparam logic [ZB-1:0] ATAN_TURNS [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
    typedef enum logic [2:0] {
        REG_LEFT = 3'd0, REG_RIGHT = 3'd1, REG_BOTTOM = 3'd2,
        REG_TOP = 3'd3, REG_RADIUS = 3'd4, REG_CORNER = 3'd5
    } t_reg_idx;
    typedef enum logic {REQ_SELECT = 1'b0, REQ_PROJECT = 1'b1} t_req;
    typedef struct packed {
        logic              valid;
        logic              req;
        logic [15:0]       heading;
        logic              in_box;
        logic              setup_ok;
    } t_side;
endpackage
`default_nettype wire

### rtl/qapp_vec_cell.sv
// One vectoring CORDIC stage: rotates toward the x axis, accumulates angle.
`default_nettype none
module qapp_vec_cell
    import qapp_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic signed [WIDE_BITS-1:0] i_x,
    input  wire logic signed [WIDE_BITS-1:0] i_y,
    input  wire logic [ZB-1:0]               i_z,
    output logic signed [WIDE_BITS-1:0]      o_x,
    output logic signed [WIDE_BITS-1:0]      o_y,
    output logic [ZB-1:0]                    o_z
);
    logic signed [WIDE_BITS-1:0] xs, ys;
    assign xs = i_x >>> STAGE;
    assign ys = i_y >>> STAGE;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_y > 0) begin
                o_x <= i_x + ys; o_y <= i_y - xs; o_z <= i_z + ATAN_TURNS[STAGE];
            end else if (i_y < 0) begin
                o_x <= i_x - ys; o_y <= i_y + xs; o_z <= i_z - ATAN_TURNS[STAGE];
            end else begin
                o_x <= i_x; o_y <= i_y; o_z <= i_z;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/qapp_rot_cell.sv
// One rotation CORDIC stage: drives residual angle toward zero.
`default_nettype none
module qapp_rot_cell
    import qapp_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic signed [WIDE_BITS-1:0] i_x,
    input  wire logic signed [WIDE_BITS-1:0] i_y,
    input  wire logic [ZB-1:0]               i_z,
    output logic signed [WIDE_BITS-1:0]      o_x,
    output logic signed [WIDE_BITS-1:0]      o_y,
    output logic [ZB-1:0]                    o_z
);
    logic signed [WIDE_BITS-1:0] xs, ys;
    assign xs = i_x >>> STAGE;
    assign ys = i_y >>> STAGE;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[ZB-1]) begin
                o_x <= i_x - ys; o_y <= i_y + xs; o_z <= i_z - ATAN_TURNS[STAGE];
            end else begin
                o_x <= i_x + ys; o_y <= i_y - xs; o_z <= i_z + ATAN_TURNS[STAGE];
            end
        end
    end
endmodule
`default_nettype wire

### rtl/quarter_arc_point_projector.sv
// Top level: quarter arc point projector, two CORDIC cell chains in a row.
// Usage:
//  Input channel i_valid/o_ready carries a request: req_type, point, heading.
//  req_type 0 selects travel direction from heading; 1 projects the point
//  onto the quarter arc around the chosen box corner.
//  Output channel o_valid/i_ready returns exactly one result per request,
//  in order.
//  Throughput: one request per cycle while the output is not stalled; the pipeline is
//  an input stage, vectoring cells, angle stages, rotation cells and an output register, all advancing together.
//  The direction bit is read and written in the last stage only, so
//  back-to-back requests see it in order.
//  When the receiver stalls, the whole chain holds; o_ready drops only
//  when the output register is full and not being taken.
//  Reset (synchronous, active low) restores default box registers and
//  clears direction state and all valid flags.
//  Config writes belong only in times when the pipeline is empty.
`default_nettype none
`include "assert_macros.svh"
module quarter_arc_point_projector
    import qapp_pkg::*;
#(
    parameter int COORD_BITS    = 24,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [2:0]                   i_cfg_idx,
    input  wire logic [COORD_BITS-1:0]        i_cfg_data,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_req_type,
    input  wire logic signed [COORD_BITS-1:0] i_point_x,
    input  wire logic signed [COORD_BITS-1:0] i_point_y,
    input  wire logic [ANGLE_BITS-1:0]        i_point_heading,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [COORD_BITS-1:0]      o_on_arc_x,
    output logic signed [COORD_BITS-1:0]      o_on_arc_y,
    output logic [ANGLE_BITS-1:0]             o_tangent_heading,
    output logic                              o_inside_box,
    output logic                              o_setup_valid
);
    localparam int N = CORDIC_STAGES;
    localparam int CW = COORD_BITS + 2;
    localparam int PRE = 60 - COORD_BITS;
    localparam int DEPTH = 2 * N + 4;
    localparam logic [ANGLE_BITS-1:0] A_HALF = {1'b1, {(ANGLE_BITS-1){1'b0}}};
    localparam logic [ANGLE_BITS-1:0] A_QTR  = {2'b01, {(ANGLE_BITS-2){1'b0}}};

    typedef struct packed {
        logic                        req;
        logic [ANGLE_BITS-1:0]       head;
        logic                        in_box;
        logic                        ok;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
    } t_tag;

    logic signed [COORD_BITS-1:0] r_left, r_right, r_bottom, r_top;
    logic [COORD_BITS-2:0]        r_radius;
    logic [1:0]                   r_corner;
    logic                         r_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_right  <= COORD_BITS'(4096);
            r_bottom <= '0;
            r_top    <= COORD_BITS'(4096);
            r_radius <= (COORD_BITS-1)'(2048);
            r_corner <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_LEFT:   r_left   <= i_cfg_data;
                REG_RIGHT:  r_right  <= i_cfg_data;
                REG_BOTTOM: r_bottom <= i_cfg_data;
                REG_TOP:    r_top    <= i_cfg_data;
                REG_RADIUS: r_radius <= i_cfg_data[COORD_BITS-2:0];
                REG_CORNER: r_corner <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // pipeline valid chain; all stages advance together
    logic [DEPTH-1:0] r_vld;
    logic             adv;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[DEPTH-2:0], i_valid};
    end

    // stage 0: center, offsets, flags
    logic signed [COORD_BITS-1:0] cx_c, cy_c;
    logic signed [CW-1:0]         dx_c, dy_c, wd_c, ht_c, rad_c;
    assign cx_c  = r_corner[0] ? r_right : r_left;
    assign cy_c  = r_corner[1] ? r_top : r_bottom;
    assign dx_c  = CW'(i_point_x) - CW'(cx_c);
    assign dy_c  = CW'(i_point_y) - CW'(cy_c);
    assign wd_c  = CW'(r_right) - CW'(r_left);
    assign ht_c  = CW'(r_top) - CW'(r_bottom);
    assign rad_c = CW'({1'b0, r_radius});

    t_tag r_tag [DEPTH];
    logic signed [WIDE_BITS-1:0] r_x0, r_y0;
    logic [ZB-1:0]               r_z0;
    logic                        r_zero0;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tag[0].req    <= i_req_type;
            r_tag[0].head   <= i_point_heading;
            r_tag[0].in_box <= i_point_x <= r_right && i_point_x >= r_left &&
                               i_point_y <= r_top && i_point_y >= r_bottom;
            r_tag[0].ok     <= r_radius != '0 && rad_c < wd_c && rad_c < ht_c;
            r_tag[0].cx     <= cx_c;
            r_tag[0].cy     <= cy_c;
            r_zero0 <= dx_c == '0 && dy_c == '0;
            if (dx_c < 0) begin
                r_x0 <= -(WIDE_BITS'(dx_c) <<< PRE);
                r_y0 <= -(WIDE_BITS'(dy_c) <<< PRE);
                r_z0 <= 32'h8000_0000;
            end else begin
                r_x0 <= WIDE_BITS'(dx_c) <<< PRE;
                r_y0 <= WIDE_BITS'(dy_c) <<< PRE;
                r_z0 <= '0;
            end
        end
    end

    for (genvar t = 1; t < DEPTH; t++) begin : g_tag
        always_ff @(posedge i_clk) if (adv) r_tag[t] <= r_tag[t-1];
    end

    logic signed [WIDE_BITS-1:0] vx [N+1];
    logic signed [WIDE_BITS-1:0] vy [N+1];
    logic [ZB-1:0]               vz [N+1];
    logic [N-1:0]                r_vzero;
    assign vx[0] = r_x0;
    assign vy[0] = r_y0;
    assign vz[0] = r_z0;
    always_ff @(posedge i_clk) if (adv) r_vzero <= {r_vzero[N-2:0], r_zero0};

    for (genvar s = 0; s < N; s++) begin : g_vec
        qapp_vec_cell #(.STAGE(s)) u_cell (
            .i_clk(i_clk), .i_en(adv),
            .i_x(vx[s]), .i_y(vy[s]), .i_z(vz[s]),
            .o_x(vx[s+1]), .o_y(vy[s+1]), .o_z(vz[s+1])
        );
    end

    // angle rounding and rotation setup
    logic [ZB-1:0]          zr_c;
    logic [ANGLE_BITS-1:0]  ang_c;
    assign zr_c  = vz[N] + (ZB'(1) << (31 - ANGLE_BITS));
    assign ang_c = r_vzero[N-1] ? '0 : zr_c[ZB-1 -: ANGLE_BITS];

    logic [ANGLE_BITS-1:0]       r_ang [N+2];
    logic signed [WIDE_BITS-1:0] r_rx;
    logic [ZB-1:0]               r_rz;
    logic [ZB-1:0]               za_c, zq_c;
    logic signed [WIDE_BITS-1:0] gx_c;
    // stage after the vectoring chain: register angle
    always_ff @(posedge i_clk) if (adv) r_ang[0] <= ang_c;
    assign za_c = {r_ang[0], {(ZB-ANGLE_BITS){1'b0}}};
    assign zq_c = za_c + 32'h4000_0000;
    assign gx_c = WIDE_BITS'($signed({1'b0, r_radius})) * WIDE_BITS'(GAIN_Q30);
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ang[1] <= r_ang[0];
            if (zq_c[ZB-1]) begin
                r_rx <= -gx_c;
                r_rz <= za_c - 32'h8000_0000;
            end else begin
                r_rx <= gx_c;
                r_rz <= za_c;
            end
        end
    end
    for (genvar t = 2; t < N + 2; t++) begin : g_ang
        always_ff @(posedge i_clk) if (adv) r_ang[t] <= r_ang[t-1];
    end

    logic signed [WIDE_BITS-1:0] rx [N+1];
    logic signed [WIDE_BITS-1:0] ry [N+1];
    logic [ZB-1:0]               rz [N+1];
    assign rx[0] = r_rx;
    assign ry[0] = '0;
    assign rz[0] = r_rz;
    for (genvar s = 0; s < N; s++) begin : g_rot
        qapp_rot_cell #(.STAGE(s)) u_cell (
            .i_clk(i_clk), .i_en(adv),
            .i_x(rx[s]), .i_y(ry[s]), .i_z(rz[s]),
            .o_x(rx[s+1]), .o_y(ry[s+1]), .o_z(rz[s+1])
        );
    end

    // final stage: round, add center, saturate, direction select
    t_tag                  tg;
    logic [ANGLE_BITS-1:0] a_f;
    logic signed [WIDE_BITS-1:0] fx_c, fy_c;
    logic signed [COORD_BITS-1:0] sx_c, sy_c;
    logic                  dsel_c, dir_use_c;
    logic [ANGLE_BITS:0]   aph_c;
    localparam logic signed [WIDE_BITS-1:0] RND = WIDE_BITS'(1) <<< 29;
    assign tg  = r_tag[DEPTH-2];
    assign a_f = r_ang[N+1];
    assign fx_c = ((rx[N] + RND) >>> 30) + WIDE_BITS'(tg.cx);
    assign fy_c = ((ry[N] + RND) >>> 30) + WIDE_BITS'(tg.cy);
    localparam logic signed [WIDE_BITS-1:0] HI = (WIDE_BITS'(1) <<< (COORD_BITS-1)) - 1;
    localparam logic signed [WIDE_BITS-1:0] LO = -HI - 1;
    assign sx_c = fx_c > HI ? HI[COORD_BITS-1:0] :
                  fx_c < LO ? LO[COORD_BITS-1:0] : fx_c[COORD_BITS-1:0];
    assign sy_c = fy_c > HI ? HI[COORD_BITS-1:0] :
                  fy_c < LO ? LO[COORD_BITS-1:0] : fy_c[COORD_BITS-1:0];
    assign aph_c = {1'b0, a_f} + {1'b0, A_HALF};
    always_comb begin
        if (!a_f[ANGLE_BITS-1])
            dsel_c = !(tg.head < a_f || {1'b0, tg.head} > aph_c);
        else
            dsel_c = tg.head >= a_f || tg.head < (a_f - A_HALF);
        dir_use_c = (t_req'(tg.req) == REQ_SELECT) ? dsel_c : r_dir;
    end

    logic fire;
    assign fire = adv && r_vld[DEPTH-2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dir <= 1'b0;
        else if (fire && t_req'(tg.req) == REQ_SELECT) r_dir <= dsel_c;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_on_arc_x <= (t_req'(tg.req) == REQ_PROJECT) ? sx_c : '0;
            o_on_arc_y <= (t_req'(tg.req) == REQ_PROJECT) ? sy_c : '0;
            o_tangent_heading <= a_f + (dir_use_c ? A_QTR : A_QTR * ANGLE_BITS'(3));
            o_inside_box  <= tg.in_box;
            o_setup_valid <= tg.ok;
        end
    end
    assign o_valid = r_vld[DEPTH-1];

    // tag r_tag[DEPTH-1] unused beyond this point except for checks
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `ASSERT_IMPLIES(a_ready_rule, i_clk, i_rst_n, !o_valid, o_ready)
    `ASSERT_NEXT(a_dir_keep, i_clk, i_rst_n, !fire, $stable(r_dir))
    `ASSERT_IMPLIES(a_tag_match, i_clk, i_rst_n, o_valid,
        o_inside_box == r_tag[DEPTH-1].in_box)
endmodule
`default_nettype wire

### bench/quarter_arc_point_projector_tb.sv
// Self-checking bench for the quarter arc point projector: queued driver, in-order checker.
`timescale 1ns / 1ps
module quarter_arc_point_projector_tb;
    import qapp_pkg::*;

    typedef struct {
        t_req             req;
        logic [23:0]      x;
        logic [23:0]      y;
        logic [15:0]      h;
    } t_pose;

    typedef struct {
        logic [23:0] x;
        logic [23:0] y;
        logic [15:0] h;
        logic        ins;
        logic        ok;
    } t_proj;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    t_reg_idx    i_cfg_idx = REG_LEFT;
    logic [23:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_req_type = 1'b0;
    logic [23:0] i_point_x = '0;
    logic [23:0] i_point_y = '0;
    logic [15:0] i_point_heading = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [23:0] o_on_arc_x;
    logic [23:0] o_on_arc_y;
    logic [15:0] o_tangent_heading;
    logic        o_inside_box;
    logic        o_setup_valid;

    quarter_arc_point_projector uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_req_type(i_req_type),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_point_heading(i_point_heading),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_on_arc_x(o_on_arc_x), .o_on_arc_y(o_on_arc_y),
        .o_tangent_heading(o_tangent_heading), .o_inside_box(o_inside_box),
        .o_setup_valid(o_setup_valid)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // box and direction mirror
    longint m_left = 0, m_right = 4096, m_bottom = 0, m_top = 4096, m_radius = 2048;
    int     m_corner = 0;
    logic   m_dir = 1'b0;

    t_pose  pending_poses[$];
    t_proj  expected_proj[$];
    t_pose  cur_pose;
    int     errors = 0;
    int     cycles = 0;
    bit     quiet = 1'b0;
    int     hold_asks = 0;
    int     hold_done = 0;

    function automatic longint centre_x();
        return (m_corner & 1) ? m_right : m_left;
    endfunction

    function automatic longint centre_y();
        return (m_corner & 2) ? m_top : m_bottom;
    endfunction

    function automatic logic [15:0] radial_turns(longint dx, longint dy);
        longint x, y, xs, ys;
        logic [31:0] z;
        if (dx == 0 && dy == 0) return 16'd0;
        x = dx * (64'sd1 <<< 36);
        y = dy * (64'sd1 <<< 36);
        z = 32'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_TURNS[i];
            end else if (y < 0) begin
                x = x - ys; y = y + xs; z = z - ATAN_TURNS[i];
            end
        end
        z = z + 32'h0000_8000;
        return z[31:16];
    endfunction

    function automatic longint clamp24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic t_proj project_pose(t_pose p);
        t_proj  r;
        longint px, py, cx, cy, x, y, xs, ys;
        logic [31:0] z;
        int     a, hd;
        px = longint'($signed(p.x));
        py = longint'($signed(p.y));
        cx = centre_x();
        cy = centre_y();
        a  = radial_turns(px - cx, py - cy);
        hd = p.h;
        r.x = '0;
        r.y = '0;
        if (p.req == REQ_SELECT) begin
            if (a < 32768) m_dir = (hd < a || hd > a + 32768) ? 1'b0 : 1'b1;
            else           m_dir = (hd >= a || hd < a - 32768) ? 1'b1 : 1'b0;
        end else begin
            x = m_radius * 64'sd652032874;
            y = 0;
            z = {a[15:0], 16'h0000};
            if (((z + 32'h4000_0000) & 32'h8000_0000) != 0) begin
                x = -x;
                z = z - 32'h8000_0000;
            end
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (!z[31]) begin
                    x = x - ys; y = y + xs; z = z - ATAN_TURNS[i];
                end else begin
                    x = x + ys; y = y - xs; z = z + ATAN_TURNS[i];
                end
            end
            r.x = 24'(clamp24(cx + ((x + (64'sd1 <<< 29)) >>> 30)));
            r.y = 24'(clamp24(cy + ((y + (64'sd1 <<< 29)) >>> 30)));
        end
        r.h = 16'(a + (m_dir ? 16384 : 49152));
        r.ins = px <= m_right && px >= m_left && py <= m_top && py >= m_bottom;
        r.ok = m_radius > 0 && m_radius < m_right - m_left && m_radius < m_top - m_bottom;
        return r;
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        logic nv;
        nv = i_valid;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_proj.push_back(project_pose(cur_pose));
                nv = 1'b0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                end else if (pending_poses.size() > 0) begin
                    if (!quiet && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(1, 7);
                    end else begin
                        cur_pose = pending_poses.pop_front();
                        i_req_type      <= cur_pose.req;
                        i_point_x       <= cur_pose.x;
                        i_point_y       <= cur_pose.y;
                        i_point_heading <= cur_pose.h;
                        nv = 1'b1;
                    end
                end
            end
            i_valid <= nv;
        end
    end

    // receiver and checker
    int recv_gap = 0;
    int recv_hold = 0;
    always @(posedge i_clk) begin
        t_proj e;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_proj.size() == 0) begin
                    $display("%0t: unexpected result x=%h y=%h", $time, o_on_arc_x, o_on_arc_y);
                    errors = errors + 1;
                end else begin
                    e = expected_proj.pop_front();
                    if (o_on_arc_x !== e.x) begin
                        $display("%0t: on_arc_x exp %h got %h", $time, e.x, o_on_arc_x);
                        errors = errors + 1;
                    end
                    if (o_on_arc_y !== e.y) begin
                        $display("%0t: on_arc_y exp %h got %h", $time, e.y, o_on_arc_y);
                        errors = errors + 1;
                    end
                    if (o_tangent_heading !== e.h) begin
                        $display("%0t: tangent_heading exp %h got %h", $time, e.h,
                                 o_tangent_heading);
                        errors = errors + 1;
                    end
                    if (o_inside_box !== e.ins) begin
                        $display("%0t: inside_box exp %b got %b", $time, e.ins, o_inside_box);
                        errors = errors + 1;
                    end
                    if (o_setup_valid !== e.ok) begin
                        $display("%0t: setup_valid exp %b got %b", $time, e.ok, o_setup_valid);
                        errors = errors + 1;
                    end
                end
            end
            if (hold_done < hold_asks) begin
                hold_done = hold_done + 1;
                recv_hold = 150;
            end
            if (recv_hold > 0) begin
                recv_hold = recv_hold - 1;
                i_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap = recv_gap - 1;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(1, 7);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 300000) begin
            $display("quarter_arc_point_projector_tb: done, errors");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [23:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_LEFT:   m_left   = longint'($signed(data));
            REG_RIGHT:  m_right  = longint'($signed(data));
            REG_BOTTOM: m_bottom = longint'($signed(data));
            REG_TOP:    m_top    = longint'($signed(data));
            REG_RADIUS: m_radius = longint'(data[22:0]);
            default:    m_corner = data[1:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_box(longint le, longint re, longint be, longint te,
                           longint rad, int cs);
        write_reg(REG_LEFT, 24'(le));
        write_reg(REG_RIGHT, 24'(re));
        write_reg(REG_BOTTOM, 24'(be));
        write_reg(REG_TOP, 24'(te));
        // top bit is outside the register and must be dropped
        write_reg(REG_RADIUS, {1'($urandom), 23'(rad)});
        write_reg(REG_CORNER, {22'($urandom), 2'(cs)});
    endtask

    task automatic drain();
        wait (pending_poses.size() == 0 && !i_valid && expected_proj.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic add_pose(t_req rq, longint x, longint y, int h);
        t_pose p;
        p.req = rq;
        p.x = 24'(x);
        p.y = 24'(y);
        p.h = 16'(h);
        pending_poses.push_back(p);
    endtask

    task automatic add_random(int n);
        longint cx, cy, span;
        t_req rq;
        for (int k = 0; k < n; k++) begin
            rq = t_req'($urandom_range(0, 1));
            cx = centre_x();
            cy = centre_y();
            span = 2 * m_radius + 64;
            if (span > 8000000) span = 8000000;
            if ($urandom_range(0, 4) == 0)
                add_pose(rq, longint'($urandom), longint'($urandom), $urandom);
            else
                add_pose(rq, cx + $urandom_range(0, 2 * span) - span,
                         cy + $urandom_range(0, 2 * span) - span, $urandom);
        end
    endtask

    initial begin
        longint le, be, w, hgt;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset box: center at origin, axis points, select boundaries
        add_pose(REQ_SELECT, 0, 0, 0);
        add_pose(REQ_PROJECT, 0, 0, 65535);
        add_pose(REQ_SELECT, 1000, 0, 32768);
        add_pose(REQ_PROJECT, 1000, 0, 0);
        add_pose(REQ_SELECT, 1000, 0, 32769);
        add_pose(REQ_PROJECT, 1000, 1000, 0);
        add_pose(REQ_SELECT, 0, 1000, 16383);
        add_pose(REQ_PROJECT, 0, 1000, 0);
        add_pose(REQ_SELECT, -1000, 0, 32768);
        add_pose(REQ_PROJECT, -1000, 0, 0);
        add_pose(REQ_SELECT, -1000, 0, 0);
        add_pose(REQ_SELECT, 0, -1000, 65535);
        add_pose(REQ_PROJECT, 0, -1000, 0);
        add_pose(REQ_SELECT, 8388607, 8388607, 65535);
        add_pose(REQ_PROJECT, -8388608, -8388608, 0);
        add_pose(REQ_PROJECT, 8388607, -8388608, 12345);
        add_pose(REQ_PROJECT, 4096, 4096, 0);
        add_pose(REQ_PROJECT, 4097, 4096, 0);
        add_random(150);
        drain();

        // widest box, largest radius: projections saturate
        set_box(-8388608, 8388607, -8388608, 8388607, 8388607, 3);
        add_pose(REQ_PROJECT, -8388608, -8388608, 0);
        add_pose(REQ_PROJECT, 8388607, 8388607, 0);
        add_pose(REQ_SELECT, 0, 8388607, 40000);
        add_pose(REQ_PROJECT, 8388607, 0, 0);
        add_random(150);
        drain();

        // zero radius: setup reported invalid; one long receiver hold
        set_box(-5000, 5000, 100, 300, 0, 1);
        add_random(150);
        hold_asks = hold_asks + 1;
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            le = longint'($urandom_range(0, 200000)) - 100000;
            be = longint'($urandom_range(0, 200000)) - 100000;
            w = $urandom_range(1, 40000);
            hgt = $urandom_range(1, 40000);
            set_box(le, le + w, be, be + hgt, $urandom_range(0, 30000), ph % 4);
            if (ph == 7) quiet = 1'b1;
            if (ph == 3) hold_asks = hold_asks + 1;
            add_random(160);
            drain();
        end

        if (errors == 0) begin
            $display("quarter_arc_point_projector_tb: done, clean");
        end else begin
            $display("quarter_arc_point_projector_tb: done, errors");
        end
        $finish;
    end
endmodule
